>>> rtl/mfcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfcr_pkg
// shared types and constants of the multitap feedback comb reverb
// ----------------------------------------------------------------------------
package mfcr_pkg;

	localparam int NUM_TAPS   = 4;
	localparam int RING_DEPTH = 8192;

	localparam int ADDR_W    = $clog2(RING_DEPTH);
	localparam int FILL_W    = ADDR_W + 1;
	localparam int LEN_W     = 14;
	localparam int DELAY_W   = 14;
	localparam int DLY_EXT_W = DELAY_W + 1;
	localparam int DECAY_W   = 16;
	localparam int DECAY_LSB = 16;
	localparam int SAMPLE_W  = 16;
	localparam int ENTRY_W   = 24;
	localparam int PROD_W    = ENTRY_W + DECAY_W + 1;
	localparam int ACC_W     = ENTRY_W + $clog2(NUM_TAPS + 1) + 1;
	localparam int TAP_CNT_W = 3;
	localparam int TAP_IDX_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP0        = 3'd2;

	localparam logic signed [ACC_W-1:0] SAT16_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT16_MIN = -ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] SAT24_MAX = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0] SAT24_MIN = -ACC_W'(8388608);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAPS,
		ST_FINISH
	} fsm_t;

	typedef struct packed {
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [ENTRY_W-1:0] wr_data;
	} ring_req_t;

	typedef struct packed {
		logic                       load;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       issue;
		logic [DECAY_W-1:0]         decay;
	} mac_ctrl_t;

	typedef struct packed {
		logic                    busy;
		logic signed [ACC_W-1:0] acc;
	} mac_stat_t;

endpackage
`default_nettype wire

>>> rtl/mfcr_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfcr_ring
// echo ring memory with registered read and a fill count; entries above the
// highest written address read as zero
// ----------------------------------------------------------------------------
module mfcr_ring (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mfcr_pkg::ring_req_t          req,
	output logic signed [mfcr_pkg::ENTRY_W-1:0] rd_data
);

	logic [mfcr_pkg::ENTRY_W-1:0] mem [mfcr_pkg::RING_DEPTH];
	logic [mfcr_pkg::ENTRY_W-1:0] rd_q;
	logic                         hit_q;
	logic [mfcr_pkg::FILL_W-1:0]  fill_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q  <= mem[req.rd_addr];
			hit_q <= ({1'b0, req.rd_addr} < fill_q);
		end
	end

	// written addresses always form a prefix starting at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (req.wr_en && ({1'b0, req.wr_addr} >= fill_q)) begin
			fill_q <= {1'b0, req.wr_addr} + mfcr_pkg::FILL_W'(1);
		end
	end

	assign rd_data = hit_q ? $signed(rd_q) : '0;

endmodule
`default_nettype wire

>>> rtl/mfcr_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfcr_mac
// multiply-accumulate pipeline: ring data times tap decay, floored, summed
// ----------------------------------------------------------------------------
module mfcr_mac (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire mfcr_pkg::mac_ctrl_t            ctrl,
	input  wire logic signed [mfcr_pkg::ENTRY_W-1:0] rd_data,
	output mfcr_pkg::mac_stat_t                 stat
);

	logic                                issue_s1;
	logic [mfcr_pkg::DECAY_W-1:0]        decay_s1;
	logic                                mul_s2;
	logic signed [mfcr_pkg::PROD_W-1:0]  prod_s2;
	logic signed [mfcr_pkg::PROD_W-1:0]  term;
	logic signed [mfcr_pkg::ACC_W-1:0]   acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			mul_s2   <= 1'b0;
		end else begin
			issue_s1 <= ctrl.issue;
			mul_s2   <= issue_s1;
		end
	end

	always_ff @(posedge clk) begin
		decay_s1 <= ctrl.decay;
		prod_s2  <= rd_data * $signed({1'b0, decay_s1});
		if (ctrl.load) begin
			acc_q <= mfcr_pkg::ACC_W'(ctrl.sample);
		end else if (mul_s2) begin
			acc_q <= acc_q + mfcr_pkg::ACC_W'(term);
		end
	end

	// arithmetic shift drops the fraction with floor rounding
	assign term = prod_s2 >>> mfcr_pkg::DECAY_LSB;

	assign stat.busy = issue_s1 | mul_s2;
	assign stat.acc  = acc_q;

endmodule
`default_nettype wire

>>> rtl/multitap_feedback_comb_reverb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multitap_feedback_comb_reverb
// feedback comb reverb with up to four taps into one 8192-entry echo ring
// ----------------------------------------------------------------------------
// One sample is taken per transaction and gives one output transaction. With
// N active taps, N above zero, an item passes through an accept step, one read
// of the single ring read port per tap, two multiply-accumulate stages and a
// write-back step that also loads the output register. With no active taps it
// passes only through the accept step and the write-back step. The output
// register lets the next sample be taken while a result still waits; the
// write-back of that next sample then waits until the output register is free.
// The ring needs no clearing pass after reset: a fill count makes never-written
// entries read as zero. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user must do so only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module multitap_feedback_comb_reverb (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [mfcr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [mfcr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [mfcr_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [mfcr_pkg::SAMPLE_W-1:0]       sample_out,
	output logic                                       clipped
);

	logic [mfcr_pkg::TAP_CNT_W-1:0]  tap_count_q;
	logic [mfcr_pkg::LEN_W-1:0]      ring_length_q;
	logic [mfcr_pkg::CFG_DATA_W-1:0] tap_setting_q [mfcr_pkg::NUM_TAPS];

	mfcr_pkg::fsm_t                  state_q, state_d;
	logic [mfcr_pkg::TAP_CNT_W-1:0]  k_q;
	logic [mfcr_pkg::ADDR_W-1:0]     wpos_q;
	logic                            out_valid_q;
	logic signed [mfcr_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                            clipped_q;

	logic [mfcr_pkg::LEN_W-1:0]      len_eff;
	logic [mfcr_pkg::TAP_CNT_W-1:0]  taps_eff;
	logic                            accept;
	logic                            fire;
	logic                            last_tap;
	logic [mfcr_pkg::CFG_DATA_W-1:0] cur_setting;
	logic [mfcr_pkg::DLY_EXT_W-1:0]  delay_raw;
	logic [mfcr_pkg::DLY_EXT_W-1:0]  delay_c;
	logic [mfcr_pkg::DLY_EXT_W-1:0]  idx_raw;
	logic [mfcr_pkg::DLY_EXT_W-1:0]  idx_wrap;
	logic [mfcr_pkg::LEN_W-1:0]      pos_next;
	logic signed [mfcr_pkg::ACC_W-1:0] acc;
	logic signed [mfcr_pkg::ACC_W-1:0] sat16;
	logic signed [mfcr_pkg::ACC_W-1:0] sat24;

	mfcr_pkg::ring_req_t ring_req;
	mfcr_pkg::mac_ctrl_t mac_ctrl;
	mfcr_pkg::mac_stat_t mac_stat;
	logic signed [mfcr_pkg::ENTRY_W-1:0] rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q   <= '0;
			ring_length_q <= mfcr_pkg::LEN_W'(mfcr_pkg::RING_DEPTH);
			for (int t = 0; t < mfcr_pkg::NUM_TAPS; t++) begin
				tap_setting_q[t] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == mfcr_pkg::CFG_TAP_COUNT) begin
				tap_count_q <= cfg_data[mfcr_pkg::TAP_CNT_W-1:0];
			end
			if (cfg_index == mfcr_pkg::CFG_RING_LENGTH) begin
				ring_length_q <= cfg_data[mfcr_pkg::LEN_W-1:0];
			end
			for (int t = 0; t < mfcr_pkg::NUM_TAPS; t++) begin
				if ({1'b0, cfg_index} ==
				    (mfcr_pkg::CFG_IDX_W + 1)'(int'(mfcr_pkg::CFG_TAP0) + t)) begin
					tap_setting_q[t] <= cfg_data;
				end
			end
		end
	end

	// effective ring length and tap count
	always_comb begin
		if (ring_length_q == '0) begin
			len_eff = mfcr_pkg::LEN_W'(1);
		end else if (ring_length_q > mfcr_pkg::LEN_W'(mfcr_pkg::RING_DEPTH)) begin
			len_eff = mfcr_pkg::LEN_W'(mfcr_pkg::RING_DEPTH);
		end else begin
			len_eff = ring_length_q;
		end
		if (tap_count_q > mfcr_pkg::TAP_CNT_W'(mfcr_pkg::NUM_TAPS)) begin
			taps_eff = mfcr_pkg::TAP_CNT_W'(mfcr_pkg::NUM_TAPS);
		end else begin
			taps_eff = tap_count_q;
		end
	end

	// read address of the current tap
	always_comb begin
		cur_setting = tap_setting_q[k_q[mfcr_pkg::TAP_IDX_W-1:0]];
		delay_raw   = {1'b0, cur_setting[mfcr_pkg::DELAY_W-1:0]} + mfcr_pkg::DLY_EXT_W'(1);
		delay_c     = (delay_raw > {1'b0, len_eff}) ? {1'b0, len_eff} : delay_raw;
		idx_raw     = mfcr_pkg::DLY_EXT_W'(wpos_q) + {1'b0, len_eff} - delay_c;
		idx_wrap    = (idx_raw >= {1'b0, len_eff}) ? idx_raw - {1'b0, len_eff} : idx_raw;
	end

	// result saturation
	always_comb begin
		acc = mac_stat.acc;
		if (acc > mfcr_pkg::SAT16_MAX) begin
			sat16 = mfcr_pkg::SAT16_MAX;
		end else if (acc < mfcr_pkg::SAT16_MIN) begin
			sat16 = mfcr_pkg::SAT16_MIN;
		end else begin
			sat16 = acc;
		end
		if (acc > mfcr_pkg::SAT24_MAX) begin
			sat24 = mfcr_pkg::SAT24_MAX;
		end else if (acc < mfcr_pkg::SAT24_MIN) begin
			sat24 = mfcr_pkg::SAT24_MIN;
		end else begin
			sat24 = acc;
		end
		pos_next = mfcr_pkg::LEN_W'(wpos_q) + mfcr_pkg::LEN_W'(1);
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		fire     = 1'b0;
		last_tap = (k_q == taps_eff - mfcr_pkg::TAP_CNT_W'(1));
		mac_ctrl.load   = 1'b0;
		mac_ctrl.sample = sample_in;
		mac_ctrl.issue  = 1'b0;
		mac_ctrl.decay  = cur_setting[mfcr_pkg::DECAY_LSB +: mfcr_pkg::DECAY_W];
		case (state_q)
			mfcr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept        = 1'b1;
					mac_ctrl.load = 1'b1;
					state_d = (taps_eff == '0) ? mfcr_pkg::ST_FINISH : mfcr_pkg::ST_TAPS;
				end
			end
			mfcr_pkg::ST_TAPS: begin
				mac_ctrl.issue = 1'b1;
				if (last_tap) begin
					state_d = mfcr_pkg::ST_FINISH;
				end
			end
			mfcr_pkg::ST_FINISH: begin
				if (!mac_stat.busy && (!out_valid_q || !out_stall)) begin
					fire    = 1'b1;
					state_d = mfcr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mfcr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			wpos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				k_q <= '0;
				// a lowered ring length can leave the write position stale
				if ({1'b0, wpos_q} >= len_eff) begin
					wpos_q <= '0;
				end
			end else if (mac_ctrl.issue) begin
				k_q <= k_q + mfcr_pkg::TAP_CNT_W'(1);
			end
			if (fire) begin
				wpos_q <= (pos_next >= len_eff) ? '0 : pos_next[mfcr_pkg::ADDR_W-1:0];
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_out_q <= sat16[mfcr_pkg::SAMPLE_W-1:0];
			clipped_q    <= (sat16 != acc);
		end
	end

	always_comb begin
		ring_req.rd_en   = mac_ctrl.issue;
		ring_req.rd_addr = idx_wrap[mfcr_pkg::ADDR_W-1:0];
		ring_req.wr_en   = fire;
		ring_req.wr_addr = wpos_q;
		ring_req.wr_data = sat24[mfcr_pkg::ENTRY_W-1:0];
	end

	mfcr_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ring_req),
		.rd_data (rd_data)
	);

	mfcr_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.rd_data (rd_data),
		.stat    (mac_stat)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule
`default_nettype wire
